>>> rtl/core/sdsf_pkg.sv
// Package for the segment display scan unit: operation codes and font ROM.
// Used by sdsf_store and segment_display_scan_with_font_unit; no dependencies.
package sdsf_pkg;

    // Operation codes carried by an input beat.
    typedef enum logic [1:0] {
        OP_WRITE_CHAR = 2'd0,
        OP_WRITE_RAW  = 2'd1,
        OP_SCAN       = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef logic [15:0] pattern_t;

    localparam pattern_t SPECIAL_PATTERN = 16'h63E9;
    localparam logic [7:0] FONT_FIRST    = 8'h20;
    localparam logic [7:0] FONT_END      = 8'h80;
    localparam int FONT_SIZE             = 96;

    // Segment patterns for character codes 0x20 through 0x7F.
    localparam pattern_t FONT_ROM [0:FONT_SIZE-1] = '{
        16'h0000, 16'h0140, 16'h1100, 16'h1794, 16'h56B4, 16'h6C9A, 16'h2E29, 16'h0800,
        16'h0808, 16'h2002, 16'h2C1A, 16'h1414, 16'h0002, 16'h0410, 16'h0040, 16'h0802,
        16'h4BA3, 16'h0980, 16'h0332, 16'h03B0, 16'h5414, 16'h4628, 16'h46B1, 16'h4380,
        16'h47B1, 16'h47B0, 16'h0220, 16'h02A0, 16'h0C08, 16'h0430, 16'h2012, 16'h4354,
        16'h07A5, 16'h4791, 16'h13B4, 16'h4221, 16'h13A4, 16'h4631, 16'h4611, 16'h42B1,
        16'h4591, 16'h1224, 16'h01A1, 16'h4C09, 16'h4021, 16'h6981, 16'h6189, 16'h43A1,
        16'h4711, 16'h43A9, 16'h4719, 16'h46B0, 16'h1204, 16'h41A1, 16'h4803, 16'h418B,
        16'h280A, 16'h2804, 16'h0A22, 16'h2222, 16'h2C14, 16'h0A28, 16'h000A, 16'h0020,
        16'h2000, 16'h04A9, 16'h44B1, 16'h0431, 16'h05B1, 16'h0423, 16'h4601, 16'h23B0,
        16'h4491, 16'h0880, 16'h08A0, 16'h4419, 16'h4001, 16'h0495, 16'h0491, 16'h04B1,
        16'h4E01, 16'h2390, 16'h0411, 16'h0038, 16'h4421, 16'h00A1, 16'h0003, 16'h008B,
        16'h041A, 16'h45B0, 16'h0422, 16'h2622, 16'h1004, 16'h0A38, 16'h0200, 16'h7FFF
    };

    // Font lookup; codes outside the printable range give the special pattern.
    function automatic pattern_t font_lookup(input logic [7:0] code);
        logic [7:0] offset;
        begin
            offset = code - FONT_FIRST;
            if (code >= FONT_FIRST && code < FONT_END)
            begin
                font_lookup = FONT_ROM[offset[6:0]];
            end
            else
            begin
                font_lookup = SPECIAL_PATTERN;
            end
        end
    endfunction

endpackage

>>> rtl/core/sdsf_store.sv
// Pattern store: one write port, two registered read ports, per-entry valid bits.
// Depends on sdsf_pkg for the pattern type.
module sdsf_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int IW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  sdsf_pkg::pattern_t  wr_data,
    input  logic                rd_en,
    input  logic [IW-1:0]       rd_addr_a,
    input  logic [IW-1:0]       rd_addr_b,
    output sdsf_pkg::pattern_t  rd_data_a,
    output sdsf_pkg::pattern_t  rd_data_b
);
    import sdsf_pkg::*;

    pattern_t           mem [0:DEPTH-1];
    logic [DEPTH-1:0]   valid_reg;
    logic               hit_a_reg;
    logic               hit_b_reg;
    pattern_t           data_a_reg;
    pattern_t           data_b_reg;
    logic               in_range_a;
    logic               in_range_b;
    logic [AW-1:0]      idx_a;
    logic [AW-1:0]      idx_b;

    // An index past the store reads as zero.
    assign in_range_a = (rd_addr_a < IW'(DEPTH));
    assign in_range_b = (rd_addr_b < IW'(DEPTH));
    assign idx_a      = rd_addr_a[AW-1:0];
    assign idx_b      = rd_addr_b[AW-1:0];

    // Memory array: write and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[idx_a];
            data_b_reg <= mem[idx_b];
        end
    end

    // Valid bits stand in for the all-zero reset of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_a_reg <= in_range_a && valid_reg[idx_a];
                hit_b_reg <= in_range_b && valid_reg[idx_b];
            end
        end
    end

    assign rd_data_a = hit_a_reg ? data_a_reg : '0;
    assign rd_data_b = hit_b_reg ? data_b_reg : '0;

endmodule

>>> rtl/core/segment_display_scan_with_font_unit.sv
// Top level of the multiplexed 14-segment display scan unit.
// Depends on sdsf_pkg and sdsf_store.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    operation, position, char_code, raw_pattern
// out       output     out_valid / out_ready  column_select, column_index,
//                                             first_pattern, second_pattern
//
// A write beat updates the store at its accept edge and gives no result.
// A scan beat reads both patterns at its accept edge; the result is offered from that
// edge on and can leave at the next one.
// One beat per cycle is taken; the output register holding a result blocks input
// only while it is full and out_ready is low.
// Reset clears the column counter, the output valid flag and the store valid bits.
module segment_display_scan_with_font_unit #(
    parameter int DIGIT_COUNT  = 16,
    parameter int SCAN_COLUMNS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdsf_pkg::op_t      operation,
    input  logic [3:0]         position,
    input  logic [7:0]         char_code,
    input  sdsf_pkg::pattern_t raw_pattern,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         column_select,
    output logic [2:0]         column_index,
    output sdsf_pkg::pattern_t first_pattern,
    output sdsf_pkg::pattern_t second_pattern
);
    import sdsf_pkg::*;

    localparam int AW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CW = (SCAN_COLUMNS > 1) ? $clog2(SCAN_COLUMNS) : 1;
    localparam int IW = ((CW > AW) ? CW : AW) + 1;
    localparam int XW = (CW > 3) ? CW : 3;

    logic              in_fire;
    logic              scan_fire;
    logic              wr_en;
    logic              pos_in_range;
    pattern_t          wr_data;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [IW-1:0]     rd_addr_a;
    logic [IW-1:0]     rd_addr_b;
    logic [XW-1:0]     col_ext;
    logic [7:0]        select_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        column_select_reg;
    logic [2:0]        column_index_reg;

    // Input handshake: take a beat unless a result is stuck in the output register.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && (operation == OP_SCAN);

    // Write path: font lookup or raw pattern, ignored past the store.
    assign pos_in_range = (32'(position) < DIGIT_COUNT);
    assign wr_en        = in_fire && pos_in_range
                          && (operation == OP_WRITE_CHAR || operation == OP_WRITE_RAW);
    assign wr_data      = (operation == OP_WRITE_CHAR) ? font_lookup(char_code) : raw_pattern;

    // Read addresses for both modules of the current column.
    assign rd_addr_a = IW'(col_reg);
    assign rd_addr_b = IW'(col_reg) + IW'(DIGIT_COUNT / 2);

    // Column select byte: one-cold with bit 7 at column 0, all ones past column 7.
    assign col_ext     = XW'(col_reg);
    assign select_next = (32'(col_reg) < 32'd8) ? ~(8'h80 >> col_ext[2:0]) : 8'hFF;

    assign col_next = (32'(col_reg) == SCAN_COLUMNS - 1) ? '0 : col_reg + CW'(1);

    sdsf_store #(
        .DEPTH (DIGIT_COUNT),
        .AW    (AW),
        .IW    (IW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (AW'(position)),
        .wr_data   (wr_data),
        .rd_en     (scan_fire),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (first_pattern),
        .rd_data_b (second_pattern)
    );

    // Output valid flag follows scan beats and drains on out_ready.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (scan_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (scan_fire)
            begin
                col_reg <= col_next;
            end
        end
    end

    // Result column fields, captured with the store read.
    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            column_select_reg <= select_next;
            column_index_reg  <= col_ext[2:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign column_select = column_select_reg;
    assign column_index  = column_index_reg;

    // A scan beat always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) scan_fire |=> out_valid_reg)
        else $error("scan beat did not produce a result");

    // A result appears only after a scan beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(scan_fire))
        else $error("result without a scan beat");

    // The column counter stays below the column count.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < SCAN_COLUMNS)
        else $error("column counter out of range");

    // At most one column is selected at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones(~column_select_reg) <= 1)
        else $error("more than one column selected");

endmodule

>>> sim/scan_check_pkg.sv
// Scoreboard for the segment display scan unit: font table, digit store and column predictor.
// Depends on sdsf_pkg for the operation codes and the pattern type.
`timescale 1ns / 100ps

package scan_check_pkg;

    import sdsf_pkg::*;

    localparam int DIGITS    = 16;
    localparam int HALF      = DIGITS / 2;
    localparam int SCAN_COLS = 8;

    // Segment patterns for character codes 0x20 through 0x7F.
    localparam pattern_t GLYPHS [0:95] = '{
        16'h0000, 16'h0140, 16'h1100, 16'h1794, 16'h56B4, 16'h6C9A, 16'h2E29, 16'h0800,
        16'h0808, 16'h2002, 16'h2C1A, 16'h1414, 16'h0002, 16'h0410, 16'h0040, 16'h0802,
        16'h4BA3, 16'h0980, 16'h0332, 16'h03B0, 16'h5414, 16'h4628, 16'h46B1, 16'h4380,
        16'h47B1, 16'h47B0, 16'h0220, 16'h02A0, 16'h0C08, 16'h0430, 16'h2012, 16'h4354,
        16'h07A5, 16'h4791, 16'h13B4, 16'h4221, 16'h13A4, 16'h4631, 16'h4611, 16'h42B1,
        16'h4591, 16'h1224, 16'h01A1, 16'h4C09, 16'h4021, 16'h6981, 16'h6189, 16'h43A1,
        16'h4711, 16'h43A9, 16'h4719, 16'h46B0, 16'h1204, 16'h41A1, 16'h4803, 16'h418B,
        16'h280A, 16'h2804, 16'h0A22, 16'h2222, 16'h2C14, 16'h0A28, 16'h000A, 16'h0020,
        16'h2000, 16'h04A9, 16'h44B1, 16'h0431, 16'h05B1, 16'h0423, 16'h4601, 16'h23B0,
        16'h4491, 16'h0880, 16'h08A0, 16'h4419, 16'h4001, 16'h0495, 16'h0491, 16'h04B1,
        16'h4E01, 16'h2390, 16'h0411, 16'h0038, 16'h4421, 16'h00A1, 16'h0003, 16'h008B,
        16'h041A, 16'h45B0, 16'h0422, 16'h2622, 16'h1004, 16'h0A38, 16'h0200, 16'h7FFF
    };

    localparam pattern_t UNKNOWN_GLYPH = 16'h63E9;

    // One column as the block should drive it.
    typedef struct packed {
        logic [7:0] col_sel;
        logic [2:0] col_idx;
        pattern_t   first;
        pattern_t   second;
    } column_beat_t;

    class scan_scoreboard;

        pattern_t     digit_store [DIGITS];
        logic [2:0]   scan_col;
        column_beat_t expected_columns [$];
        int           errors;

        function new();
            foreach (digit_store[i])
                digit_store[i] = '0;
            scan_col = '0;
            errors   = 0;
        endfunction

        // Pattern a character write stores; codes outside the font get the fallback glyph.
        function pattern_t glyph_for(logic [7:0] code);
            if (code >= 8'h20 && code < 8'h80)
                return GLYPHS[code - 8'h20];
            return UNKNOWN_GLYPH;
        endfunction

        function int pending();
            return expected_columns.size();
        endfunction

        // Apply one accepted input beat to the predicted state.
        function void note_beat(op_t op, logic [3:0] pos, logic [7:0] code, pattern_t raw);
            column_beat_t col;
            case (op)
                OP_WRITE_CHAR: digit_store[pos] = glyph_for(code);
                OP_WRITE_RAW:  digit_store[pos] = raw;
                OP_SCAN:
                begin
                    col.col_sel = ~(8'h80 >> scan_col);
                    col.col_idx = scan_col;
                    col.first   = digit_store[scan_col];
                    col.second  = digit_store[HALF + scan_col];
                    expected_columns.push_back(col);
                    if (scan_col == 3'(SCAN_COLS - 1))
                        scan_col = '0;
                    else
                        scan_col = scan_col + 3'd1;
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted output beat with the oldest predicted column.
        function void check_column(logic [7:0] sel, logic [2:0] idx, pattern_t p1, pattern_t p2);
            column_beat_t exp_col;
            if (expected_columns.size() == 0)
            begin
                $display("%0t: output beat with nothing expected: sel %h col %0d %h %h",
                         $time, sel, idx, p1, p2);
                errors++;
                return;
            end
            exp_col = expected_columns.pop_front();
            if (sel !== exp_col.col_sel)
            begin
                $display("%0t: column_select expected %h actual %h", $time, exp_col.col_sel, sel);
                errors++;
            end
            if (idx !== exp_col.col_idx)
            begin
                $display("%0t: column_index expected %0d actual %0d", $time, exp_col.col_idx, idx);
                errors++;
            end
            if (p1 !== exp_col.first)
            begin
                $display("%0t: first_pattern expected %h actual %h", $time, exp_col.first, p1);
                errors++;
            end
            if (p2 !== exp_col.second)
            begin
                $display("%0t: second_pattern expected %h actual %h", $time, exp_col.second, p2);
                errors++;
            end
        endfunction

    endclass

endpackage

>>> sim/tb.sv
// Testbench for segment_display_scan_with_font_unit: directed and random beats, random stalls.
// Depends on sdsf_pkg, scan_check_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;

    import sdsf_pkg::*;
    import scan_check_pkg::*;

    localparam int RANDOM_BEATS = 1450;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 400;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    op_t        operation;
    logic [3:0] position;
    logic [7:0] char_code;
    pattern_t   raw_pattern;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] column_select;
    logic [2:0] column_index;
    pattern_t   first_pattern;
    pattern_t   second_pattern;

    scan_scoreboard sb;
    int             stall_cycles = 0;

    segment_display_scan_with_font_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .position       (position),
        .char_code      (char_code),
        .raw_pattern    (raw_pattern),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .column_select  (column_select),
        .column_index   (column_index),
        .first_pattern  (first_pattern),
        .second_pattern (second_pattern)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Accepted beats go to the scoreboard; outputs first so a new scan cannot match itself.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_column(column_select, column_index, first_pattern, second_pattern);
            if (in_valid && in_ready)
                sb.note_beat(operation, position, char_code, raw_pattern);
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** segment_display_scan_with_font_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: out_ready walks a random 16-bit ready pattern that is redrawn periodically, plus one long hold-off.
    initial
    begin : receiver
        int          cyc;
        logic [15:0] ready_pattern;
        out_ready     = 1'b0;
        cyc           = 0;
        ready_pattern = 16'hFFFF;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cyc % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom_range(0, 65535)) | 16'h8421;
                    default: ready_pattern = 16'($urandom_range(0, 65535));
                endcase
            end
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                out_ready <= 1'b0;
            else
                out_ready <= ready_pattern[cyc % 16];
            cyc++;
        end
    end

    // Offer one beat and hold it until it is taken.
    task automatic send_beat(input op_t op, input logic [3:0] pos, input logic [7:0] code,
                             input pattern_t raw);
        @(negedge clk);
        in_valid    <= 1'b1;
        operation   <= op;
        position    <= pos;
        char_code   <= code;
        raw_pattern <= raw;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid for a number of cycles.
    task automatic idle_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Pause the sender until every predicted column has come out.
    task automatic drain_columns();
        idle_gap(1);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        // A full scan of the cleared store, wrapping back to column 0.
        repeat (9)
            send_beat(OP_SCAN, 4'd0, 8'h00, 16'h0000);
        // Font edges and codes on both sides of the font range.
        send_beat(OP_WRITE_CHAR, 4'd0,  8'h30, 16'h0000);
        send_beat(OP_WRITE_CHAR, 4'd15, 8'h7F, 16'h0000);
        send_beat(OP_WRITE_CHAR, 4'd7,  8'h1F, 16'h0000);
        send_beat(OP_WRITE_CHAR, 4'd8,  8'h80, 16'h0000);
        send_beat(OP_WRITE_CHAR, 4'd1,  8'h20, 16'hFFFF);
        send_beat(OP_WRITE_CHAR, 4'd9,  8'hFF, 16'hFFFF);
        send_beat(OP_WRITE_CHAR, 4'd2,  8'h00, 16'h0000);
        // Raw writes at the extremes.
        send_beat(OP_WRITE_RAW, 4'd3,  8'hFF, 16'hFFFF);
        send_beat(OP_WRITE_RAW, 4'd10, 8'h41, 16'h0000);
        send_beat(OP_WRITE_RAW, 4'd11, 8'h00, 16'hA5A5);
        // The unused operation must leave the store and the column alone.
        send_beat(OP_NONE, 4'd4, 8'h41, 16'hFFFF);
        repeat (8)
            send_beat(OP_SCAN, 4'd15, 8'hFF, 16'hFFFF);
    endtask

    // Random beats in bursts; one pause halfway that lets the output drain.
    task automatic run_random(input int count);
        int         sent;
        int         burst_left;
        int         r;
        op_t        op;
        logic [3:0] pos;
        logic [7:0] code;
        pattern_t   raw;
        sent       = 0;
        burst_left = $urandom_range(1, 40);
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                op = OP_WRITE_CHAR;
            else if (r < 58)
                op = OP_WRITE_RAW;
            else if (r < 95)
                op = OP_SCAN;
            else
                op = OP_NONE;
            pos = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 9) < 7)
                code = 8'($urandom_range(8'h20, 8'h7F));
            else
                code = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                0:       raw = 16'hFFFF;
                1:       raw = 16'h0000;
                default: raw = 16'($urandom_range(0, 65535));
            endcase
            send_beat(op, pos, code, raw);
            sent++;
            if (sent == count / 2)
                drain_columns();
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 12));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    // Main sequence: reset, stimulus, drain, verdict.
    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_NONE;
        position     = '0;
        char_code    = '0;
        raw_pattern  = '0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(RANDOM_BEATS);

        idle_gap(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t: %0d expected columns never came out", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("** segment_display_scan_with_font_unit: PASSED **");
        else
            $display("** segment_display_scan_with_font_unit: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/sdsf_pkg.sv
rtl/core/sdsf_store.sv
rtl/core/segment_display_scan_with_font_unit.sv
sim/scan_check_pkg.sv
sim/tb.sv
